FILE: design/ordered_key_set_macros.svh
// Assertion macros shared by the ordered key set checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ORDERED_KEY_SET_MACROS_SVH
`define ORDERED_KEY_SET_MACROS_SVH

// Clocked property, switched off while reset is held
`define OKS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Overlapping implication on top of the clocked form
`define OKS_IMPLIES(label, ante, cons, msg) \
    `OKS_ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication on top of the clocked form
`define OKS_IMPLIES_NEXT(label, ante, cons, msg) \
    `OKS_ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

FILE: design/oks_pkg.sv
// Shared types, operation codes and helpers for the ordered key set.
// Used by oks_cell, ordered_key_set and oks_checker; depends on nothing.
package oks_pkg;

    localparam int unsigned CAPACITY = 32;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OP_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_EXISTS = 3'd2;
    localparam logic [OP_W-1:0] OP_SUCC   = 3'd3;
    localparam logic [OP_W-1:0] OP_PRED   = 3'd4;

    typedef logic signed [KEY_W-1:0] t_key;

    // One request: operation and key
    typedef struct packed {
        logic [OP_W-1:0] operation;
        t_key            key;
    } t_req;

    // One response
    typedef struct packed {
        logic found;
        t_key result_key;
        logic full_error;
    } t_rsp;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic capture;   // latch compare flags against cmp_key
        t_key cmp_key;   // key under test, also the key to insert
        logic ins;       // open a gap and insert cmp_key
        logic del;       // close the gap over the matching cell
        logic sel_succ;  // report the successor cell
        logic sel_pred;  // report the predecessor cell
    } t_bcast;

    // What one cell shows to its neighbors and to the top level
    typedef struct packed {
        t_key key;
        logic valid;
        logic lt;        // valid and key below the compare key
        logic eq;        // valid and key equal to the compare key
        logic gt;        // valid and key above the compare key
        logic hit;       // this cell is the requested neighbor key
        t_key sel_key;   // key when hit, zero otherwise
    } t_cell;

    // Map two's complement onto unsigned order
    function automatic logic [KEY_W-1:0] biased(input t_key k);
        return {~k[KEY_W-1], k[KEY_W-2:0]};
    endfunction

endpackage

FILE: design/oks_cell.sv
// One slot of the sorted key chain: key, valid bit and compare flags.
// Depends on oks_pkg; trades keys with its left and right neighbors.
module oks_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  oks_pkg::t_bcast i_bc,
    input  oks_pkg::t_cell  i_left,
    input  oks_pkg::t_cell  i_right,
    output oks_pkg::t_cell  o_cell
);

    oks_pkg::t_key r_key;
    oks_pkg::t_key n_key;
    logic          r_valid;
    logic          n_valid;
    logic          r_lt;
    logic          r_eq;
    logic          r_gt;
    logic          w_lt;
    logic          w_eq;
    logic          w_hit;

    // Compare the stored key with the broadcast key
    assign w_lt = r_valid
               && (oks_pkg::biased(r_key) < oks_pkg::biased(i_bc.cmp_key));
    assign w_eq = r_valid && (r_key == i_bc.cmp_key);

    // Hold compare flags for the request in flight
    always_ff @(posedge i_clk) begin
        if (i_bc.capture) begin
            r_lt <= w_lt;
            r_eq <= w_eq;
            r_gt <= r_valid && !w_lt && !w_eq;
        end
    end

    // Successor: first cell above the key; predecessor: last cell below it
    assign w_hit = (i_bc.sel_succ && r_gt && !i_left.gt)
                || (i_bc.sel_pred && r_lt && !i_right.lt);

    // Shift right on insert, shift left on delete, from the key position on
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_bc.ins && !r_lt) begin
            if (i_left.lt) begin
                n_key   = i_bc.cmp_key;
                n_valid = 1'b1;
            end else begin
                n_key   = i_left.key;
                n_valid = i_left.valid;
            end
        end else if (i_bc.del && !r_lt) begin
            n_key   = i_right.key;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Show state to neighbors and to the result gather
    assign o_cell.key     = r_key;
    assign o_cell.valid   = r_valid;
    assign o_cell.lt      = r_lt;
    assign o_cell.eq      = r_eq;
    assign o_cell.gt      = r_gt;
    assign o_cell.hit     = w_hit;
    assign o_cell.sel_key = w_hit ? r_key : '0;

endmodule

FILE: design/ordered_key_set.sv
// Ordered key set: a sorted set of up to CAPACITY distinct signed 32-bit keys
// kept in a row of cells, slot 0 holding the smallest key. Each request
// (insert, delete, exists, successor, predecessor) gives one response. A
// request is handled in a compare step and an update step: in the cycle it is
// accepted every cell compares its key with the request key, and in the update
// state that follows the row shifts one slot right (insert) or left (delete)
// from the key position while the response register loads. A response still
// stalled at the output holds the update state until it drains. No clearing pass follows reset.
// Depends on oks_pkg and oks_cell.
module ordered_key_set (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  oks_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output oks_pkg::t_rsp o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    localparam oks_pkg::t_cell LEFT_EDGE = '{
        key: '0, valid: 1'b1, lt: 1'b1, eq: 1'b0, gt: 1'b0, hit: 1'b0, sel_key: '0
    };
    localparam oks_pkg::t_cell RIGHT_EDGE = '0;

    logic           r_state;
    logic           n_state;
    oks_pkg::t_req  r_req;
    logic           r_rsp_valid;
    oks_pkg::t_rsp  r_rsp;
    oks_pkg::t_rsp  n_rsp;
    oks_pkg::t_bcast w_bc;
    oks_pkg::t_cell w_cell [oks_pkg::CAPACITY];
    logic           w_accept;
    logic           w_commit;
    logic           w_present;
    logic           w_hit;
    oks_pkg::t_key  w_sel_key;
    logic           w_full;

    assign o_req_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_commit    = (r_state == S_UPD) && (!r_rsp_valid || !i_rsp_stall);

    // Hold the request in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // Gather match, hit and selected key across the row
    always_comb begin
        w_present = 1'b0;
        w_hit     = 1'b0;
        w_sel_key = '0;
        for (int unsigned c = 0; c < oks_pkg::CAPACITY; c++) begin
            w_present = w_present | w_cell[c].eq;
            w_hit     = w_hit | w_cell[c].hit;
            w_sel_key = w_sel_key | w_cell[c].sel_key;
        end
    end

    assign w_full = w_cell[oks_pkg::CAPACITY-1].valid;

    // Drive the broadcast to the cells
    always_comb begin
        w_bc.capture  = w_accept;
        w_bc.cmp_key  = (r_state == S_IDLE) ? i_req.key : r_req.key;
        w_bc.ins      = w_commit && (r_req.operation == oks_pkg::OP_INSERT)
                     && !w_present && !w_full;
        w_bc.del      = w_commit && (r_req.operation == oks_pkg::OP_DELETE) && w_present;
        w_bc.sel_succ = (r_req.operation == oks_pkg::OP_SUCC);
        w_bc.sel_pred = (r_req.operation == oks_pkg::OP_PRED);
    end

    // Build the row, tying the ends to fixed edge cells
    for (genvar g = 0; g < oks_pkg::CAPACITY; g++) begin : g_cell
        oks_pkg::t_cell w_left;
        oks_pkg::t_cell w_right;
        if (g == 0) begin : g_first
            assign w_left = LEFT_EDGE;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == oks_pkg::CAPACITY - 1) begin : g_last
            assign w_right = RIGHT_EDGE;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        oks_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bc    (w_bc),
            .i_left  (w_left),
            .i_right (w_right),
            .o_cell  (w_cell[g])
        );
    end

    // Form the response for the request in flight
    always_comb begin
        n_rsp = '0;
        unique case (r_req.operation) inside
            oks_pkg::OP_INSERT: n_rsp.full_error = !w_present && w_full;
            oks_pkg::OP_EXISTS: n_rsp.found = w_present;
            oks_pkg::OP_SUCC, oks_pkg::OP_PRED: begin
                n_rsp.found      = w_hit;
                n_rsp.result_key = w_sel_key;
            end
            default: n_rsp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
    end

    // Advance the two-step sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: design/oks_checker.sv
// Port-level checks for ordered_key_set, bound to the top level.
// Depends on oks_pkg and ordered_key_set_macros.svh.
`include "ordered_key_set_macros.svh"

module oks_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input oks_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input oks_pkg::t_rsp o_rsp
);

    // A stalled response keeps its payload
    `OKS_IMPLIES_NEXT(a_rsp_hold, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp), "stalled response changed")

    // One request at a time: the cycle after a request the input stalls
    `OKS_IMPLIES_NEXT(a_one_in_flight, i_req_valid && !o_req_stall, o_req_stall, "second request taken too early")

    // A dropped insert never reports a found key
    `OKS_IMPLIES(a_found_vs_full, o_rsp_valid, !(o_rsp.found && o_rsp.full_error), "found and full_error together")

    // No key is reported without found
    `OKS_IMPLIES(a_key_zero, o_rsp_valid && !o_rsp.found, o_rsp.result_key == '0, "result_key set without found")

endmodule

bind ordered_key_set oks_checker u_oks_checker (.*);
